### rtl/core/prti_pkg.sv
// Package for the pump run-timer and interlock block.
// Holds the word types, codes and reset values shared by every file of the block.
// Depends on nothing.
package prti_pkg;

  // Pump layout: pumps 0 to 2 dose, pump 3 waters, pump 4 refills the tank.
  localparam int PUMP_COUNT  = 5;
  localparam int TIMED_PUMPS = 4;
  localparam int WATER_PUMP  = 3;
  localparam int REFILL_PUMP = 4;

  // Run timers count in tenths of a millisecond, so a tick takes ten off.
  localparam int TIMER_W = 32;
  localparam logic [TIMER_W-1:0] TICK_TENTHS = 32'd10;
  // A watering unit of 0.1 s is 1000 tenths of a millisecond.
  localparam logic [9:0] WATER_SCALE = 10'd1000;

  localparam int CFG_W = 16;

  // Register reset values.
  localparam logic [15:0] MS_PER_ML_RESET = 16'd1000;
  localparam logic [11:0] CRITICAL_RESET  = 12'd100;
  localparam logic [11:0] SAFETY_RESET    = 12'd950;
  localparam logic        CLEANER_RESET   = 1'b0;

  localparam logic RUN_AMOUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEVEL = 2'd1,
    OP_OFF   = 2'd2,
    OP_RUN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE               = 3'd0,
    EV_RAISED_INVALID     = 3'd1,
    EV_RAISED_LOW         = 3'd2,
    EV_CLEARED_NORMAL     = 3'd3,
    EV_CLEARED_SUPPRESSED = 3'd4
  } alert_t;

  typedef enum logic [1:0] {
    REG_MS_PER_ML = 2'd0,
    REG_CRITICAL  = 2'd1,
    REG_SAFETY    = 2'd2,
    REG_CLEANER   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t         op;
    logic        run_kind;
    logic [2:0]  pump_index;
    logic [15:0] amount_tenths;
    logic [11:0] level_mm;
    logic        level_valid;
  } cmd_word_t;

  typedef struct packed {
    logic [PUMP_COUNT-1:0] pumps_running;
    logic [PUMP_COUNT-1:0] pumps_changed;
    logic                  buzzer;
    alert_t                alert_event;
    status_t               status;
  } res_word_t;

  typedef struct packed {
    logic [15:0] ms_per_ml;
    logic [11:0] critical_level_mm;
    logic [11:0] safety_level_mm;
    logic        cleaner_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic [PUMP_COUNT-1:0] running;
    logic [PUMP_COUNT-1:0] changed;
    status_t               status;
  } pump_res_t;

  typedef struct packed {
    logic   buzzer;
    alert_t alert_event;
  } alarm_res_t;

endpackage

### rtl/core/prti_pump_ctrl.sv
// Pump state, run timers and start interlock of the pump run-timer block.
// Decodes one command word per step and updates the pumps in the same cycle.
// Depends on prti_pkg.
module prti_pump_ctrl import prti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  cmd_word_t cmd,
  input  cfg_regs_t cfg,
  output pump_res_t res
);

  // A timer that holds less than this before a tick reaches zero milliseconds.
  localparam logic [TIMER_W-1:0] STOP_BELOW = TICK_TENTHS + TICK_TENTHS;

  logic [PUMP_COUNT-1:0] pump_on;
  logic [PUMP_COUNT-1:0] pump_on_next;
  logic [TIMER_W-1:0]    remaining [TIMED_PUMPS];
  logic [TIMER_W-1:0]    remaining_next [TIMED_PUMPS];
  logic [TIMER_W-1:0]    dose_tenths;
  logic [TIMER_W-1:0]    water_tenths;
  logic [TIMER_W-1:0]    run_tenths;
  logic                  index_ok;
  status_t               status;

  // Run length in tenths of a millisecond: one multiplier for dosing.
  assign dose_tenths  = 32'(cmd.amount_tenths) * 32'(cfg.ms_per_ml);
  assign water_tenths = 32'(cmd.amount_tenths) * 32'(WATER_SCALE);
  assign run_tenths   = (cmd.pump_index == 3'(WATER_PUMP)) ? water_tenths : dose_tenths;
  assign index_ok     = cmd.pump_index < 3'(PUMP_COUNT);

  // Next pump state for the command at hand.
  always_comb begin
    pump_on_next   = pump_on;
    remaining_next = remaining;
    status         = ST_OK;
    unique case (cmd.op)
      OP_TICK: begin
        for (int i = 0; i < TIMED_PUMPS; i++) begin
          if (pump_on[i] && remaining[i] >= TICK_TENTHS) begin
            remaining_next[i] = remaining[i] - TICK_TENTHS;
            if (remaining[i] < STOP_BELOW) begin
              pump_on_next[i] = 1'b0;
            end
          end
        end
      end
      OP_LEVEL: begin
        // The refill pump is cut off once a valid level reaches the safety level.
        if (pump_on[REFILL_PUMP] && cmd.level_valid &&
            cmd.level_mm >= cfg.safety_level_mm) begin
          pump_on_next[REFILL_PUMP] = 1'b0;
        end
      end
      OP_OFF: begin
        if (!index_ok) begin
          status = ST_INVALID;
        end else begin
          for (int i = 0; i < PUMP_COUNT; i++) begin
            if (cmd.pump_index == 3'(i)) begin
              pump_on_next[i] = 1'b0;
            end
          end
          for (int i = 0; i < TIMED_PUMPS; i++) begin
            if (cmd.pump_index == 3'(i)) begin
              remaining_next[i] = '0;
            end
          end
        end
      end
      OP_RUN: begin
        priority if (!index_ok) begin
          status = ST_INVALID;
        end else if (cmd.pump_index == 3'(REFILL_PUMP)) begin
          // Refill runs untimed and is not interlocked.
          if (cmd.run_kind == RUN_AMOUNT) begin
            status = ST_INVALID;
          end else begin
            pump_on_next[REFILL_PUMP] = 1'b1;
          end
        end else if (cmd.run_kind != RUN_AMOUNT || cmd.amount_tenths == '0) begin
          status = ST_INVALID;
        end else if (|pump_on) begin
          status = ST_BUSY;
        end else if (run_tenths < TICK_TENTHS) begin
          // The run would last less than one millisecond.
          status = ST_INVALID;
        end else begin
          for (int i = 0; i < TIMED_PUMPS; i++) begin
            if (cmd.pump_index == 3'(i)) begin
              pump_on_next[i]   = 1'b1;
              remaining_next[i] = run_tenths;
            end
          end
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Pump and timer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pump_on <= '0;
      for (int i = 0; i < TIMED_PUMPS; i++) begin
        remaining[i] <= '0;
      end
    end else if (step) begin
      pump_on   <= pump_on_next;
      remaining <= remaining_next;
    end
  end

  assign res.running = pump_on_next;
  assign res.changed = pump_on_next ^ pump_on;
  assign res.status  = status;

endmodule

### rtl/core/prti_alarm.sv
// Low-level alarm of the pump run-timer block.
// Tracks the alarm on level samples, reports its edges and drives the buzzer.
// Depends on prti_pkg.
module prti_alarm import prti_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cmd_word_t  cmd,
  input  cfg_regs_t  cfg,
  output alarm_res_t res
);

  logic   alarm_active;
  logic   alarm_active_next;
  logic   enabled;
  logic   should;
  alert_t event_code;

  assign enabled = !cfg.cleaner_mode;
  assign should  = enabled && (!cmd.level_valid || cmd.level_mm <= cfg.critical_level_mm);

  // Only level samples move the alarm, and only its edges give an event.
  always_comb begin
    alarm_active_next = alarm_active;
    event_code        = EV_NONE;
    if (cmd.op == OP_LEVEL) begin
      if (should && !alarm_active) begin
        alarm_active_next = 1'b1;
        event_code        = cmd.level_valid ? EV_RAISED_LOW : EV_RAISED_INVALID;
      end else if (!should && alarm_active) begin
        alarm_active_next = 1'b0;
        event_code        = enabled ? EV_CLEARED_NORMAL : EV_CLEARED_SUPPRESSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_active <= 1'b0;
    end else if (step) begin
      alarm_active <= alarm_active_next;
    end
  end

  assign res.buzzer      = alarm_active_next && !cfg.cleaner_mode;
  assign res.alert_event = event_code;

endmodule

### rtl/core/pump_run_timer_interlock.sv
// Top level of the pump run-timer and interlock block.
// Holds the input and result registers and the configuration registers.
// Depends on prti_pkg, prti_pump_ctrl and prti_alarm.
//
// One command word is taken per clock cycle while res_ready does not hold the
// result back: the word is captured in an input register, then the pump, timer
// and alarm state is updated and the result registered in the same cycle, so
// each word sees the state left by the one before it. While a finished
// result waits for res_ready, the input register can still take one more word
// and then holds it until the result is taken. Run timers count internally in
// tenths of a millisecond, so dosing time needs one 16 by 16 multiply and no
// divide. Configuration writes are taken in any cycle (cfg_ready is always high)
// and should be made only while no word is in flight.
module pump_run_timer_interlock import prti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_word_t        cmd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output res_word_t        res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  reg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_regs_t  cfg;
  cmd_word_t  cmd_q;
  logic       cmd_q_valid;
  logic       advance;
  pump_res_t  pump_res;
  alarm_res_t alarm_res;

  // The held word moves on whenever the result register is free or being emptied.
  assign advance   = cmd_q_valid && (!res_valid || res_ready);
  assign cmd_ready = !cmd_q_valid || advance;
  assign cfg_ready = 1'b1;

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid           <= 1'b0;
      res_valid             <= 1'b0;
      cfg.ms_per_ml         <= MS_PER_ML_RESET;
      cfg.critical_level_mm <= CRITICAL_RESET;
      cfg.safety_level_mm   <= SAFETY_RESET;
      cfg.cleaner_mode      <= CLEANER_RESET;
    end else begin
      if (cmd_valid && cmd_ready) begin
        cmd_q_valid <= 1'b1;
      end else if (advance) begin
        cmd_q_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MS_PER_ML: cfg.ms_per_ml         <= cfg_data[15:0];
          REG_CRITICAL:  cfg.critical_level_mm <= cfg_data[11:0];
          REG_SAFETY:    cfg.safety_level_mm   <= cfg_data[11:0];
          REG_CLEANER:   cfg.cleaner_mode      <= cfg_data[0];
          default:       cfg.cleaner_mode      <= cfg.cleaner_mode;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd_data;
    end
    if (advance) begin
      res_data.pumps_running <= pump_res.running;
      res_data.pumps_changed <= pump_res.changed;
      res_data.buzzer        <= alarm_res.buzzer;
      res_data.alert_event   <= alarm_res.alert_event;
      res_data.status        <= pump_res.status;
    end
  end

  prti_pump_ctrl u_pump_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .res  (pump_res)
  );

  prti_alarm u_alarm (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .res  (alarm_res)
  );

endmodule

### rtl/core/prti_checker.sv
// Port-level checker for the pump run-timer block, bound to its top level.
// Watches the result channel and reset behavior over time.
// Depends on prti_pkg and pump_run_timer_interlock.
module prti_checker import prti_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      cmd_ready,
  input logic      res_valid,
  input logic      res_ready,
  input res_word_t res_data
);

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  // Leaving reset, the block is empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("block not empty after reset");

  // A refused or invalid command changes no pump.
  a_refused_no_change: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |-> res_data.pumps_changed == '0)
    else $error("pump changed on a refused command");

  // No word starts more than one pump.
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones(res_data.pumps_running & res_data.pumps_changed) <= 1)
    else $error("more than one pump started by one word");

  // A raised alarm always sounds the buzzer.
  a_raise_buzz: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.alert_event == EV_RAISED_LOW ||
                  res_data.alert_event == EV_RAISED_INVALID) |-> res_data.buzzer)
    else $error("alarm raised without buzzer");

endmodule

bind pump_run_timer_interlock prti_checker u_prti_checker (.*);

### test/pump_run_timer_interlock_tb.sv
`timescale 1ns / 1ps
// Testbench for pump_run_timer_interlock: a directed table followed by random command words,
// every result word checked against a cycle-free model of pumps, timers and alarm.
// Depends on prti_pkg and the block's RTL only.
module pump_run_timer_interlock_tb;
  import prti_pkg::*;

  typedef struct {
    cmd_word_t w;
    bit        typed;
    res_word_t want;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_word_t        cmd_data  = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_word_t        res_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  reg_idx_t         cfg_index = REG_MS_PER_ML;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Model state: registers, pump flags, run timers in whole ms and the alarm flag.
  cfg_regs_t             cfg_now = {MS_PER_ML_RESET, CRITICAL_RESET, SAFETY_RESET, CLEANER_RESET};
  logic [PUMP_COUNT-1:0] pump_on = '0;
  logic [31:0]           run_left [PUMP_COUNT];
  logic                  alarm_on = 1'b0;

  res_word_t awaited_words[$];
  dir_row_t  dir_rows[$];
  cfg_regs_t phase_cfg [6];
  res_word_t want_word;
  int        mismatch_count = 0;
  int        result_no = 0;
  int        steady_left = 0;

  pump_run_timer_interlock i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one command word to the model state and returns the result word it gives.
  function automatic res_word_t next_pump_word(input cmd_word_t w);
    res_word_t             r;
    logic [PUMP_COUNT-1:0] was;
    logic [31:0]           dur;
    logic                  enabled;
    logic                  should;
    status_t               st;
    alert_t                ev;
    was = pump_on;
    st  = ST_OK;
    ev  = EV_NONE;
    case (w.op)
      OP_TICK: begin
        for (int i = 0; i < PUMP_COUNT; i++) begin
          if (pump_on[i] && run_left[i] != 0) begin
            run_left[i] = run_left[i] - 1;
            if (run_left[i] == 0) pump_on[i] = 1'b0;
          end
        end
      end
      OP_LEVEL: begin
        // Refill cut-off comes first, then the alarm edge.
        if (pump_on[REFILL_PUMP] && w.level_valid && w.level_mm >= cfg_now.safety_level_mm) begin
          pump_on[REFILL_PUMP]  = 1'b0;
          run_left[REFILL_PUMP] = '0;
        end
        enabled = !cfg_now.cleaner_mode;
        should  = enabled && (!w.level_valid || w.level_mm <= cfg_now.critical_level_mm);
        if (should && !alarm_on) begin
          alarm_on = 1'b1;
          ev = w.level_valid ? EV_RAISED_LOW : EV_RAISED_INVALID;
        end else if (!should && alarm_on) begin
          alarm_on = 1'b0;
          ev = enabled ? EV_CLEARED_NORMAL : EV_CLEARED_SUPPRESSED;
        end
      end
      OP_OFF: begin
        if (w.pump_index >= PUMP_COUNT) begin
          st = ST_INVALID;
        end else begin
          pump_on[w.pump_index]  = 1'b0;
          run_left[w.pump_index] = '0;
        end
      end
      default: begin
        // Refill runs untimed and skips the interlock; timed pumps need an amount.
        if (w.pump_index >= PUMP_COUNT) begin
          st = ST_INVALID;
        end else if (w.pump_index == REFILL_PUMP) begin
          if (w.run_kind == RUN_AMOUNT) st = ST_INVALID;
          else pump_on[REFILL_PUMP] = 1'b1;
        end else if (w.run_kind != RUN_AMOUNT || w.amount_tenths == 0) begin
          st = ST_INVALID;
        end else if (pump_on != '0) begin
          st = ST_BUSY;
        end else begin
          if (w.pump_index == WATER_PUMP) dur = 32'(w.amount_tenths) * 32'd100;
          else dur = (32'(w.amount_tenths) * 32'(cfg_now.ms_per_ml)) / 32'd10;
          if (dur == 0) begin
            st = ST_INVALID;
          end else begin
            pump_on[w.pump_index]  = 1'b1;
            run_left[w.pump_index] = dur;
          end
        end
      end
    endcase
    r.pumps_running = pump_on;
    r.pumps_changed = pump_on ^ was;
    r.buzzer        = alarm_on && !cfg_now.cleaner_mode;
    r.alert_event   = ev;
    r.status        = st;
    return r;
  endfunction

  function automatic cmd_word_t cw(input op_t op, input logic kind, input logic [2:0] p,
                                   input logic [15:0] amt, input logic [11:0] lvl,
                                   input logic vld);
    cmd_word_t w;
    w.op            = op;
    w.run_kind      = kind;
    w.pump_index    = p;
    w.amount_tenths = amt;
    w.level_mm      = lvl;
    w.level_valid   = vld;
    return w;
  endfunction

  function automatic res_word_t rw(input logic [4:0] run, input logic [4:0] chg,
                                   input logic buz, input alert_t ev, input status_t st);
    res_word_t r;
    r.pumps_running = run;
    r.pumps_changed = chg;
    r.buzzer        = buz;
    r.alert_event   = ev;
    r.status        = st;
    return r;
  endfunction

  task automatic add_row(input cmd_word_t w, input bit typed, input res_word_t want);
    dir_row_t row;
    row.w     = w;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed commands with small amounts so timers expire, plus noise words.
  function automatic cmd_word_t random_cmd();
    cmd_word_t   w;
    int          r;
    int          idx;
    logic [11:0] base;
    w.run_kind      = 1'($urandom);
    w.pump_index    = 3'($urandom);
    w.amount_tenths = 16'($urandom);
    w.level_mm      = 12'($urandom);
    w.level_valid   = 1'($urandom);
    r = $urandom_range(99, 0);
    if (r < 40) begin
      w.op = OP_TICK;
    end else if (r < 60) begin
      w.op = OP_LEVEL;
      w.level_valid = ($urandom_range(99, 0) < 85);
      r = $urandom_range(9, 0);
      // Land on either side of the alarm and cut-off thresholds most of the time.
      if (r < 6) begin
        base = (r < 3) ? cfg_now.critical_level_mm : cfg_now.safety_level_mm;
        w.level_mm = base + 12'(r % 3) - 12'd1;
      end
    end else if (r < 72) begin
      w.op = OP_OFF;
      r = $urandom_range(99, 0);
      if (r < 50 && pump_on != '0) begin
        do idx = $urandom_range(PUMP_COUNT - 1, 0); while (!pump_on[idx]);
        w.pump_index = 3'(idx);
      end else if (r < 92) begin
        w.pump_index = 3'($urandom_range(PUMP_COUNT - 1, 0));
      end
    end else begin
      w.op = OP_RUN;
      r = $urandom_range(99, 0);
      if (r < 20) begin
        w.run_kind   = ~RUN_AMOUNT;
        w.pump_index = 3'(REFILL_PUMP);
      end else if (r < 80) begin
        w.run_kind = RUN_AMOUNT;
        if ($urandom_range(4, 0) == 0) w.pump_index = 3'(WATER_PUMP);
        else w.pump_index = 3'($urandom_range(WATER_PUMP - 1, 0));
        if (r < 75) w.amount_tenths = 16'($urandom_range(8, 1));
        else w.amount_tenths = '0;
      end
    end
    return w;
  endfunction

  // Offers one command word and waits for it to be taken; the model advances on acceptance.
  task automatic send_word(input cmd_word_t w, input bit typed, input res_word_t want);
    res_word_t got;
    cmd_valid <= 1'b1;
    cmd_data  <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    got = next_pump_word(w);
    awaited_words.push_back(typed ? want : got);
  endtask

  // Random gap after a word, with stretches of back-to-back words.
  task automatic idle_gap();
    int r;
    int g;
    g = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(99, 0);
      if (r < 5) steady_left = $urandom_range(80, 30);
      else if (r < 55) g = 0;
      else if (r < 90) g = $urandom_range(3, 1);
      else g = $urandom_range(40, 8);
    end
    if (g > 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back and mirrors them into the model.
  task automatic write_regs(input cfg_regs_t c);
    reg_idx_t         idx;
    logic [CFG_W-1:0] d;
    for (int k = 0; k < 4; k++) begin
      idx = reg_idx_t'(k);
      case (idx)
        REG_MS_PER_ML: d = c.ms_per_ml;
        REG_CRITICAL:  d = {4'b0, c.critical_level_mm};
        REG_SAFETY:    d = {4'b0, c.safety_level_mm};
        default:       d = {15'b0, c.cleaner_mode};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_MS_PER_ML: cfg_now.ms_per_ml         = d;
        REG_CRITICAL:  cfg_now.critical_level_mm = d[11:0];
        REG_SAFETY:    cfg_now.safety_level_mm   = d[11:0];
        default:       cfg_now.cleaner_mode      = d[0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d, at %0t ns",
             result_no, what, got, want, $time);
    mismatch_count++;
  endtask

  // Result side: random stalls, mostly short, some long, and long stretches held ready.
  initial begin
    int r;
    forever begin
      r = $urandom_range(99, 0);
      if (r < 60) begin
        res_ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else if (r < 90) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end else if (r < 96) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(40, 10)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(200, 60)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      result_no++;
      if (awaited_words.size() == 0) begin
        report_mismatch("word with none pending", int'(res_data), 0);
      end else begin
        want_word = awaited_words.pop_front();
        if (res_data.pumps_running !== want_word.pumps_running)
          report_mismatch("pumps_running", res_data.pumps_running, want_word.pumps_running);
        if (res_data.pumps_changed !== want_word.pumps_changed)
          report_mismatch("pumps_changed", res_data.pumps_changed, want_word.pumps_changed);
        if (res_data.buzzer !== want_word.buzzer)
          report_mismatch("buzzer", res_data.buzzer, want_word.buzzer);
        if (res_data.alert_event !== want_word.alert_event)
          report_mismatch("alert_event", res_data.alert_event, want_word.alert_event);
        if (res_data.status !== want_word.status)
          report_mismatch("status", res_data.status, want_word.status);
      end
    end
  end

  initial begin
    res_word_t none;
    none = '0;
    foreach (run_left[i]) run_left[i] = '0;

    // Directed table, run with the reset register values.
    add_row(cw(OP_TICK, 1'b1, 3'd7, 16'hFFFF, 12'hFFF, 1'b1), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_OFF, 1'b0, 3'd7, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_INVALID));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd5, 16'd10, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_INVALID));
    add_row(cw(OP_RUN, ~RUN_AMOUNT, 3'd0, 16'd10, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_INVALID));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd4, 16'd10, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_INVALID));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd2, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_INVALID));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd3, 16'd1, 12'd0, 1'b0), 1,
            rw(5'b01000, 5'b01000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd0, 16'd5, 12'd0, 1'b0), 1,
            rw(5'b01000, 5'b00000, 1'b0, EV_NONE, ST_BUSY));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd3, 16'hFFFF, 12'd0, 1'b0), 1,
            rw(5'b01000, 5'b00000, 1'b0, EV_NONE, ST_BUSY));
    add_row(cw(OP_RUN, ~RUN_AMOUNT, 3'd4, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b11000, 5'b10000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_RUN, ~RUN_AMOUNT, 3'd4, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b11000, 5'b00000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_TICK, 1'b0, 3'd0, 16'd0, 12'd0, 1'b0), 0, none);
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'd949, 1'b1), 1,
            rw(5'b11000, 5'b00000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'd950, 1'b1), 1,
            rw(5'b01000, 5'b10000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_OFF, 1'b0, 3'd3, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b01000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_OFF, 1'b0, 3'd3, 16'd0, 12'd0, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_NONE, ST_OK));
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'hFFF, 1'b0), 1,
            rw(5'b00000, 5'b00000, 1'b1, EV_RAISED_INVALID, ST_OK));
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'd100, 1'b1), 1,
            rw(5'b00000, 5'b00000, 1'b1, EV_NONE, ST_OK));
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'd101, 1'b1), 1,
            rw(5'b00000, 5'b00000, 1'b0, EV_CLEARED_NORMAL, ST_OK));
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd1, 16'hFFFF, 12'd0, 1'b0), 0, none);
    add_row(cw(OP_RUN, ~RUN_AMOUNT, 3'd4, 16'd0, 12'd0, 1'b0), 0, none);
    add_row(cw(OP_TICK, 1'b0, 3'd0, 16'd0, 12'd0, 1'b0), 0, none);
    add_row(cw(OP_LEVEL, 1'b0, 3'd0, 16'd0, 12'd0, 1'b1), 0, none);
    add_row(cw(OP_OFF, 1'b0, 3'd1, 16'd0, 12'd0, 1'b0), 0, none);
    add_row(cw(OP_RUN, RUN_AMOUNT, 3'd0, 16'hFFFF, 12'd0, 1'b0), 1,
            rw(5'b10000, 5'b00000, 1'b1, EV_NONE, ST_BUSY));

    // Register settings per random phase; the first turns cleaner mode on with the alarm up.
    phase_cfg[0] = {16'd10,    12'd100,  12'd950,  1'b1};
    phase_cfg[1] = {16'd0,     12'd0,    12'd4095, 1'b0};
    phase_cfg[2] = {16'd65535, 12'd4095, 12'd0,    1'b0};
    phase_cfg[3] = {16'd3,     12'd500,  12'd600,  1'b0};
    phase_cfg[4] = {16'd1,     12'd2000, 12'd2500, 1'b1};
    phase_cfg[5] = {16'd25,    12'd100,  12'd950,  1'b0};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
      idle_gap();
    end
    cmd_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_regs(phase_cfg[ph]);
      for (int n = 0; n < 250; n++) begin
        send_word(random_cmd(), 0, none);
        idle_gap();
      end
      cmd_valid <= 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
rtl/core/prti_pkg.sv
rtl/core/prti_pump_ctrl.sv
rtl/core/prti_alarm.sv
rtl/core/pump_run_timer_interlock.sv
rtl/core/prti_checker.sv
test/pump_run_timer_interlock_tb.sv
